/* hw/rtl/multilevel_feedback_queue_scheduler_macros.svh */
// assertion macros for the multilevel feedback queue scheduler checker
// no dependencies; included by the checker file
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_MACROS_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define MFQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfq check failed");

// next-cycle implication
`define MFQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfq check failed");

`endif

/* hw/rtl/mfq_pkg.sv */
`timescale 1ns / 1ps
// shared types and codes for the multilevel feedback queue scheduler
// no dependencies
package mfq_pkg;
  localparam int NUM_SLICES = 4;

  localparam logic [1:0] OP_ADMIT    = 2'd0;
  localparam logic [1:0] OP_DISPATCH = 2'd1;
  localparam logic [1:0] OP_BOOST    = 2'd2;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef logic [15:0] slice_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  pid;
    logic [15:0] work;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  sid;
    logic [1:0]  slv;
    logic [1:0]  nlv;
    logic [15:0] left;
    logic        done;
  } res_t;
endpackage

/* hw/rtl/mfq_front.sv */
`timescale 1ns / 1ps
// front end: accepts input beats into a two-entry command queue
// depends on mfq_pkg
module mfq_front import mfq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_process_id,
  input  logic [15:0] in_work_amount,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);
  cmd_t       ent_r [2];
  logic       wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;

  assign full      = (cnt_r == 2'd2);
  assign do_push   = push && !full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = ent_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r ^ do_push;
    rptr_nxt = rptr_r ^ cmd_pop;
    cnt_nxt  = cnt_r + 2'(do_push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wptr_r] <= '{op: in_operation, pid: in_process_id, work: in_work_amount};
    end
  end
endmodule

/* hw/rtl/mfq_rfifo.sv */
`timescale 1ns / 1ps
// two-entry result queue between the engine and the output ports
// depends on mfq_pkg
module mfq_rfifo import mfq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic res_push,
  input  res_t res,
  output logic res_full,
  output logic empty,
  input  logic pop,
  output res_t dout
);
  res_t       ent_r [2];
  logic       wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign res_full = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_pop   = pop && !empty;
  assign dout     = ent_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r ^ res_push;
    rptr_nxt = rptr_r ^ do_pop;
    cnt_nxt  = cnt_r + 2'(res_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      ent_r[wptr_r] <= res;
    end
  end
endmodule

/* hw/rtl/mfq_engine.sv */
`timescale 1ns / 1ps
// back end: slot memories, level queues, free list and the command sequencer
// depends on mfq_pkg
module mfq_engine import mfq_pkg::*; #(
  parameter int NUM_LEVELS = 4,
  parameter int MAX_PROCS  = 64
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   cmd_valid,
  input  cmd_t   cmd,
  output logic   cmd_pop,
  input  slice_t slice [NUM_SLICES],
  input  logic   res_full,
  output logic   res_push,
  output res_t   res
);
  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam logic [LW-1:0] LAST_LV = LW'(NUM_LEVELS - 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_PROCS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADM  = 2'd1;
  localparam logic [1:0] ST_DSP  = 2'd2;
  localparam logic [1:0] ST_BST  = 2'd3;

  logic [1:0]      state_r, state_nxt;
  logic [SW-1:0]   head_r [NUM_LEVELS];
  logic [SW-1:0]   head_nxt [NUM_LEVELS];
  logic [SW-1:0]   tail_r [NUM_LEVELS];
  logic [SW-1:0]   tail_nxt [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] ne_r, ne_nxt;
  logic [SW-1:0]   free_head_r, free_head_nxt;
  logic [SW:0]     free_cnt_r, free_cnt_nxt;
  logic [SW:0]     fresh_r, fresh_nxt;
  logic [LW-1:0]   lv_r, lv_nxt;
  logic [7:0]      pid_r, pid_nxt;
  logic [15:0]     work_r, work_nxt;

  logic [7:0]      id_mem [MAX_PROCS];
  logic [15:0]     rem_mem [MAX_PROCS];
  logic [SW-1:0]   link_mem [MAX_PROCS];
  logic [7:0]      id_rd_r;
  logic [15:0]     rem_rd_r;
  logic [SW-1:0]   link_rd_r;
  logic [SW-1:0]   rd_addr;
  logic            id_we, rem_we, link_we;
  logic [SW-1:0]   slot_addr, link_waddr, link_wdata;
  logic [15:0]     rem_wdata;

  logic            found;
  logic [LW-1:0]   hit_lv;
  logic [SW-1:0]   dsp_slot;
  logic [1:0]      dsp_sidx;
  logic            dsp_more, dsp_last;
  logic [15:0]     dsp_left;
  logic [LW-1:0]   dsp_nl;
  logic            adm_fresh;
  logic [SW-1:0]   adm_link;

  // highest priority nonempty level
  always_comb begin
    found  = 1'b0;
    hit_lv = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (ne_r[i]) begin
        found  = 1'b1;
        hit_lv = LW'(i);
      end
    end
  end

  assign dsp_slot = head_r[lv_r];
  assign dsp_sidx = (int'(lv_r) < NUM_SLICES) ? 2'(lv_r) : 2'(NUM_SLICES - 1);
  assign dsp_more = rem_rd_r > slice[dsp_sidx];
  assign dsp_left = rem_rd_r - slice[dsp_sidx];
  assign dsp_nl   = (lv_r == LAST_LV) ? lv_r : lv_r + LW'(1);
  assign dsp_last = (dsp_slot == tail_r[lv_r]);

  // slots above the fill mark still hold the reset chain
  assign adm_fresh = ({1'b0, free_head_r} >= fresh_r);
  assign adm_link  = !adm_fresh ? link_rd_r :
                     (free_head_r == LAST_SLOT) ? '0 : free_head_r + SW'(1);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    ne_nxt        = ne_r;
    free_head_nxt = free_head_r;
    free_cnt_nxt  = free_cnt_r;
    fresh_nxt     = fresh_r;
    lv_nxt        = lv_r;
    pid_nxt       = pid_r;
    work_nxt      = work_r;
    cmd_pop       = 1'b0;
    res_push      = 1'b0;
    res           = '0;
    rd_addr       = free_head_r;
    id_we         = 1'b0;
    rem_we        = 1'b0;
    link_we       = 1'b0;
    slot_addr     = free_head_r;
    rem_wdata     = work_r;
    link_waddr    = tail_r[0];
    link_wdata    = free_head_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && !res_full) begin
          cmd_pop  = 1'b1;
          pid_nxt  = cmd.pid;
          work_nxt = cmd.work;
          unique case (cmd.op)
            OP_ADMIT: begin
              if (free_cnt_r == '0) begin
                res_push   = 1'b1;
                res.status = STAT_FULL;
                res.sid    = cmd.pid;
              end else begin
                state_nxt = ST_ADM;
              end
            end
            OP_DISPATCH: begin
              if (!found) begin
                res_push   = 1'b1;
                res.status = STAT_EMPTY;
              end else begin
                lv_nxt    = hit_lv;
                rd_addr   = head_r[hit_lv];
                state_nxt = ST_DSP;
              end
            end
            OP_BOOST: begin
              lv_nxt    = LW'(1);
              state_nxt = ST_BST;
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      ST_ADM: begin
        id_we         = 1'b1;
        rem_we        = 1'b1;
        free_head_nxt = adm_link;
        free_cnt_nxt  = free_cnt_r - 1'b1;
        if (adm_fresh) fresh_nxt = fresh_r + 1'b1;
        if (ne_r[0]) begin
          link_we    = 1'b1;
          link_waddr = tail_r[0];
          link_wdata = free_head_r;
        end else begin
          head_nxt[0] = free_head_r;
        end
        tail_nxt[0] = free_head_r;
        ne_nxt[0]   = 1'b1;
        res_push    = 1'b1;
        res.sid     = pid_r;
        res.left    = work_r;
        state_nxt   = ST_IDLE;
      end
      ST_DSP: begin
        // pop first, then requeue so a single-entry lowest level refills cleanly
        if (dsp_last) ne_nxt[lv_r] = 1'b0;
        else          head_nxt[lv_r] = link_rd_r;
        slot_addr = dsp_slot;
        rem_we    = 1'b1;
        res.sid   = id_rd_r;
        res.slv   = 2'(lv_r);
        if (dsp_more) begin
          rem_wdata = dsp_left;
          if (ne_nxt[dsp_nl]) begin
            link_we    = 1'b1;
            link_waddr = tail_r[dsp_nl];
            link_wdata = dsp_slot;
          end else begin
            head_nxt[dsp_nl] = dsp_slot;
          end
          tail_nxt[dsp_nl] = dsp_slot;
          ne_nxt[dsp_nl]   = 1'b1;
          res.nlv          = 2'(dsp_nl);
          res.left         = dsp_left;
        end else begin
          rem_wdata     = '0;
          link_we       = 1'b1;
          link_waddr    = dsp_slot;
          link_wdata    = free_head_r;
          free_head_nxt = dsp_slot;
          free_cnt_nxt  = free_cnt_r + 1'b1;
          res.done      = 1'b1;
        end
        res_push  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_BST: begin
        // one level spliced onto level 0 per cycle
        if (ne_r[lv_r]) begin
          if (ne_r[0]) begin
            link_we    = 1'b1;
            link_waddr = tail_r[0];
            link_wdata = head_r[lv_r];
          end else begin
            head_nxt[0] = head_r[lv_r];
          end
          tail_nxt[0]    = tail_r[lv_r];
          ne_nxt[0]      = 1'b1;
          ne_nxt[lv_r]   = 1'b0;
          head_nxt[lv_r] = '0;
          tail_nxt[lv_r] = '0;
        end
        if (lv_r == LAST_LV) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          lv_nxt = lv_r + LW'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ne_r        <= '0;
      free_head_r <= '0;
      free_cnt_r  <= (SW+1)'(MAX_PROCS);
      fresh_r     <= '0;
      lv_r        <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      ne_r        <= ne_nxt;
      free_head_r <= free_head_nxt;
      free_cnt_r  <= free_cnt_nxt;
      fresh_r     <= fresh_nxt;
      lv_r        <= lv_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pid_r  <= pid_nxt;
    work_r <= work_nxt;
  end

  always_ff @(posedge clk) begin
    if (id_we)   id_mem[slot_addr]   <= pid_r;
    if (rem_we)  rem_mem[slot_addr]  <= rem_wdata;
    if (link_we) link_mem[link_waddr] <= link_wdata;
    id_rd_r   <= id_mem[rd_addr];
    rem_rd_r  <= rem_mem[rd_addr];
    link_rd_r <= link_mem[rd_addr];
  end
endmodule

/* hw/rtl/multilevel_feedback_queue_scheduler.sv */
`timescale 1ns / 1ps
// Multilevel feedback queue scheduler: a two-entry command queue feeds a
// sequencer that owns the slot memories (id, remaining work, link) and the
// per-level head/tail pointers; results leave through a two-entry queue.
// One item is worked at a time. Admit and dispatch go through the sequencer
// as a memory read, then an update; a table-full or nothing-to-dispatch
// answer and an unused opcode are given straight from idle, and boost
// splices one level per step, as the link memory has a single write port.
// The free list is kept with a fill mark, so no clearing pass follows reset.
// Slice registers sit at byte addresses 0, 4, 8 and 12.
module multilevel_feedback_queue_scheduler import mfq_pkg::*; #(
  parameter int NUM_LEVELS = 4,
  parameter int MAX_PROCS  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_process_id,
  input  logic [15:0] in_work_amount,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_status,
  output logic [7:0]  out_served_id,
  output logic [1:0]  out_served_level,
  output logic [1:0]  out_next_level,
  output logic [15:0] out_work_left,
  output logic        out_completed,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  slice_t slice_r [NUM_SLICES];
  logic   cmd_valid, cmd_pop, res_full, res_push;
  cmd_t   cmd;
  res_t   res, dout;

  assign pready = 1'b1;
  assign prdata = {16'd0, slice_r[paddr[3:2]]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_r[0] <= 16'd4;
      slice_r[1] <= 16'd8;
      slice_r[2] <= 16'd12;
      slice_r[3] <= 16'd16;
    end else if (psel && penable && pwrite) begin
      slice_r[paddr[3:2]] <= pwdata[15:0];
    end
  end

  mfq_front u_front (
    .clk, .rst_n, .push, .full, .in_operation, .in_process_id, .in_work_amount,
    .cmd_valid, .cmd, .cmd_pop
  );

  mfq_engine #(.NUM_LEVELS(NUM_LEVELS), .MAX_PROCS(MAX_PROCS)) u_engine (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_pop, .slice(slice_r),
    .res_full, .res_push, .res
  );

  mfq_rfifo u_rfifo (
    .clk, .rst_n, .res_push, .res, .res_full, .empty, .pop, .dout
  );

  assign out_status       = dout.status;
  assign out_served_id    = dout.sid;
  assign out_served_level = dout.slv;
  assign out_next_level   = dout.nlv;
  assign out_work_left    = dout.left;
  assign out_completed    = dout.done;
endmodule

/* hw/rtl/mfq_checker.sv */
`timescale 1ns / 1ps
// port-level checker for the scheduler, bound to the top level
// depends on multilevel_feedback_queue_scheduler_macros.svh
`include "multilevel_feedback_queue_scheduler_macros.svh"
module mfq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  out_status,
  input logic [1:0]  out_served_level,
  input logic [1:0]  out_next_level,
  input logic [15:0] out_work_left,
  input logic        out_completed
);
  `MFQ_ASSERT_IMPL(a_status_legal, !empty, out_status != 2'd3)
  `MFQ_ASSERT_IMPL(a_done_clean, !empty && out_completed, out_work_left == 16'd0 && out_next_level == 2'd0)
  `MFQ_ASSERT_IMPL(a_empty_clean, !empty && out_status == 2'd1, out_work_left == 16'd0 && !out_completed && out_served_level == 2'd0)
  `MFQ_ASSERT_NEXT(a_beat_held, !empty && !pop, !empty)
endmodule

bind multilevel_feedback_queue_scheduler mfq_checker u_mfq_checker (.*);

/* sim/tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for the multilevel feedback queue scheduler
// depends on mfq_pkg and multilevel_feedback_queue_scheduler; predicts each result beat
module tb;
  import mfq_pkg::*;

  localparam int LEVELS = 4;
  localparam int SLOTS = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int REG_SLICE0 = 0;
  localparam int REG_SLICE1 = 1;
  localparam int REG_SLICE2 = 2;
  localparam int REG_SLICE3 = 3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic [1:0] in_operation = '0;
  logic [7:0] in_process_id = '0;
  logic [15:0] in_work_amount = '0;
  logic [1:0] out_status, out_served_level, out_next_level;
  logic [7:0] out_served_id;
  logic [15:0] out_work_left;
  logic out_completed;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  multilevel_feedback_queue_scheduler i_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_operation(in_operation), .in_process_id(in_process_id),
    .in_work_amount(in_work_amount), .empty(empty), .pop(pop),
    .out_status(out_status), .out_served_id(out_served_id),
    .out_served_level(out_served_level), .out_next_level(out_next_level),
    .out_work_left(out_work_left), .out_completed(out_completed),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // scheduler shadow state
  slice_t slice_len [LEVELS];
  logic [7:0] pid_of [SLOTS];
  logic [15:0] work_of [SLOTS];
  int link_of [SLOTS];
  int head_of [LEVELS];
  int tail_of [LEVELS];
  bit busy_lvl [LEVELS];
  int free_top;
  int free_slots;
  res_t expected_q [$];

  int mismatches = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit timed_out = 1'b0;

  function automatic void sched_reset();
    slice_len[0] = 16'd4; slice_len[1] = 16'd8;
    slice_len[2] = 16'd12; slice_len[3] = 16'd16;
    for (int i = 0; i < SLOTS; i++) link_of[i] = (i + 1) % SLOTS;
    for (int l = 0; l < LEVELS; l++) begin
      head_of[l] = 0; tail_of[l] = 0; busy_lvl[l] = 1'b0;
    end
    free_top = 0;
    free_slots = SLOTS;
  endfunction

  function automatic void enqueue(int lvl, int s);
    if (busy_lvl[lvl]) link_of[tail_of[lvl]] = s;
    else head_of[lvl] = s;
    tail_of[lvl] = s;
    busy_lvl[lvl] = 1'b1;
  endfunction

  function automatic res_t schedule(cmd_t c);
    res_t r;
    int lvl, s, nl;
    r = '0;
    case (c.op)
      OP_ADMIT: begin
        r.sid = c.pid;
        if (free_slots == 0) begin
          r.status = STAT_FULL;
        end else begin
          s = free_top;
          free_top = link_of[s];
          free_slots--;
          pid_of[s] = c.pid;
          work_of[s] = c.work;
          enqueue(0, s);
          r.left = c.work;
        end
      end
      OP_DISPATCH: begin
        lvl = 0;
        while (lvl < LEVELS && !busy_lvl[lvl]) lvl++;
        if (lvl == LEVELS) begin
          r.status = STAT_EMPTY;
        end else begin
          s = head_of[lvl];
          if (s == tail_of[lvl]) busy_lvl[lvl] = 1'b0;
          else head_of[lvl] = link_of[s];
          r.sid = pid_of[s];
          r.slv = lvl[1:0];
          if (work_of[s] > slice_len[lvl]) begin
            nl = (lvl + 1 < LEVELS) ? lvl + 1 : lvl;
            work_of[s] = work_of[s] - slice_len[lvl];
            enqueue(nl, s);
            r.nlv = nl[1:0];
            r.left = work_of[s];
          end else begin
            work_of[s] = '0;
            link_of[s] = free_top;
            free_top = s;
            free_slots++;
            r.done = 1'b1;
          end
        end
      end
      OP_BOOST: begin
        for (int l = 1; l < LEVELS; l++) begin
          if (busy_lvl[l]) begin
            if (busy_lvl[0]) link_of[tail_of[0]] = head_of[l];
            else head_of[0] = head_of[l];
            tail_of[0] = tail_of[l];
            busy_lvl[0] = 1'b1;
            busy_lvl[l] = 1'b0;
            head_of[l] = 0;
            tail_of[l] = 0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_cmd(logic [1:0] op, logic [7:0] pid, logic [15:0] work);
    cmd_t c;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    c.op = op; c.pid = pid; c.work = work;
    push <= 1'b1;
    in_operation <= op;
    in_process_id <= pid;
    in_work_amount <= work;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_q.push_back(schedule(c));
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_slice(int idx, logic [15:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(4 * idx); pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    slice_len[idx] = val;
    @(posedge clk);
  endtask

  // result beats, checked against the oldest prediction
  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat status=%0d", out_status);
        end else begin
          want = expected_q.pop_front();
          if (out_status !== want.status || out_served_id !== want.sid ||
              out_served_level !== want.slv || out_next_level !== want.nlv ||
              out_work_left !== want.left || out_completed !== want.done) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp %0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d",
                want.status, want.sid, want.slv, want.nlv, want.left, want.done,
                out_status, out_served_id, out_served_level, out_next_level,
                out_work_left, out_completed);
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no command, result or register beat
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_directed();
    send_cmd(OP_DISPATCH, 8'd0, 16'd0);        // nothing queued
    send_cmd(OP_ADMIT, 8'hff, 16'hffff);
    send_cmd(OP_ADMIT, 8'h00, 16'h0000);
    send_cmd(OP_ADMIT, 8'h5a, 16'd4);          // exactly one slice
    send_cmd(OP_ADMIT, 8'ha5, 16'd30);
    send_cmd(OP_UNUSED, 8'h77, 16'h1234);
    repeat (5) send_cmd(OP_DISPATCH, 8'd0, 16'd0);
    send_cmd(OP_BOOST, 8'h12, 16'h3456);
    repeat (6) send_cmd(OP_DISPATCH, 8'd0, 16'd0);
    send_cmd(OP_BOOST, 8'd0, 16'd0);           // boost with levels 0 to 2 empty
    drain();
  endtask

  task automatic test_table_full();
    for (int i = 0; i < SLOTS + 2; i++)
      send_cmd(OP_ADMIT, 8'(i), 16'($urandom_range(1, 40)));
    send_cmd(OP_BOOST, 8'd0, 16'd0);
    for (int i = 0; i < 4 * SLOTS; i++) send_cmd(OP_DISPATCH, 8'd0, 16'd0);
    drain();
  endtask

  task automatic test_slices();
    // zero slice requeues unchanged work, maximum slice completes everything
    write_slice(REG_SLICE0, 16'd0); write_slice(REG_SLICE1, 16'hffff);
    write_slice(REG_SLICE2, 16'd1); write_slice(REG_SLICE3, 16'd0);
    send_cmd(OP_ADMIT, 8'd9, 16'd0);
    send_cmd(OP_ADMIT, 8'd10, 16'd5);
    repeat (4) send_cmd(OP_DISPATCH, 8'd0, 16'd0);
    drain();
    write_slice(REG_SLICE0, 16'hffff); write_slice(REG_SLICE1, 16'd1);
    write_slice(REG_SLICE2, 16'd2); write_slice(REG_SLICE3, 16'd3);
    send_cmd(OP_ADMIT, 8'd11, 16'hffff);
    send_cmd(OP_ADMIT, 8'd12, 16'd7);
    repeat (6) send_cmd(OP_DISPATCH, 8'd0, 16'd0);
    drain();
  endtask

  task automatic random_phase(int n, int sidle, int rstall);
    int k;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 40) send_cmd(OP_ADMIT, 8'($urandom), ($urandom_range(3) == 0) ?
                           16'($urandom) : 16'($urandom_range(60)));
      else if (k < 92) send_cmd(OP_DISPATCH, 8'($urandom), 16'($urandom));
      else if (k < 98) send_cmd(OP_BOOST, 8'($urandom), 16'($urandom));
      else send_cmd(OP_UNUSED, 8'($urandom), 16'($urandom));
    end
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_random();
    random_phase(400, 0, 0);
    for (int r = REG_SLICE0; r <= REG_SLICE3; r++) write_slice(r, 16'($urandom_range(1, 20)));
    random_phase(400, 58, 0);
    for (int r = REG_SLICE0; r <= REG_SLICE3; r++) write_slice(r, 16'($urandom_range(1, 6)));
    random_phase(400, 0, 58);
    write_slice(REG_SLICE0, 16'd1); write_slice(REG_SLICE3, 16'hffff);
    random_phase(340, 16, 16);
  endtask

  initial begin
    sched_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    pop <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_slices();
    test_random();
    if (mismatches == 0 && expected_q.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/mfq_pkg.sv
hw/rtl/mfq_front.sv
hw/rtl/mfq_rfifo.sv
hw/rtl/mfq_engine.sv
hw/rtl/multilevel_feedback_queue_scheduler.sv
hw/rtl/mfq_checker.sv
sim/tb.sv
